>>> hw/rtl/id3fw_pkg.sv
// Package for the ID3v2 frame walker: result kinds, result record,
// header constants and the synchsafe accumulation helper.
// No dependencies.
package id3fw_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned IdW    = 32;
  localparam int unsigned SizeW  = 28;
  localparam int unsigned FlagW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ShiftW = 48;

  localparam logic [23:0]      TagMagic = 24'h494433;
  localparam logic [SizeW-1:0] HdrLen   = 28'd10;
  localparam logic [SizeW-1:0] ExtMin   = 28'd4;

  typedef enum logic [KindW-1:0] {
    KIND_TAG_HDR   = 3'd0,
    KIND_FRAME_HDR = 3'd1,
    KIND_PAYLOAD   = 3'd2,
    KIND_PADDING   = 3'd3,
    KIND_OVERFLOW  = 3'd4,
    KIND_EXT_LARGE = 3'd5,
    KIND_NO_MAGIC  = 3'd6,
    KIND_TAG_END   = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [IdW-1:0]   frame_id;
    logic [SizeW-1:0] size_value;
    logic [FlagW-1:0] flag_bits;
    logic [ByteW-1:0] tag_major;
    logic [ByteW-1:0] tag_revision;
    logic [ByteW-1:0] payload_byte;
    logic             last_of_frame;
  } result_t;

  function automatic logic [SizeW-1:0] syn7(input logic [SizeW-1:0] acc,
                                            input logic [ByteW-1:0] b);
    return {acc[SizeW-8:0], b[6:0]};
  endfunction

endpackage

>>> hw/rtl/id3fw_in_if.sv
// Input channel of the ID3v2 frame walker: one tag byte per transaction.
// Depends on id3fw_pkg.
interface id3fw_in_if;
  logic                       valid;
  logic                       ready;
  logic [id3fw_pkg::ByteW-1:0] tag_byte;
  logic                       start_of_tag;

  modport source (output valid, output tag_byte, output start_of_tag, input ready);
  modport sink   (input valid, input tag_byte, input start_of_tag, output ready);
endinterface

>>> hw/rtl/id3fw_out_if.sv
// Result channel of the ID3v2 frame walker: one result record per transaction.
// Depends on id3fw_pkg.
interface id3fw_out_if;
  logic                        valid;
  logic                        ready;
  logic [id3fw_pkg::KindW-1:0]  kind;
  logic [id3fw_pkg::IdW-1:0]    frame_id;
  logic [id3fw_pkg::SizeW-1:0]  size_value;
  logic [id3fw_pkg::FlagW-1:0]  flag_bits;
  logic [id3fw_pkg::ByteW-1:0]  tag_major;
  logic [id3fw_pkg::ByteW-1:0]  tag_revision;
  logic [id3fw_pkg::ByteW-1:0]  payload_byte;
  logic                        last_of_frame;

  modport source (output valid, output kind, output frame_id, output size_value,
                  output flag_bits, output tag_major, output tag_revision,
                  output payload_byte, output last_of_frame, input ready);
  modport sink   (input valid, input kind, input frame_id, input size_value,
                  input flag_bits, input tag_major, input tag_revision,
                  input payload_byte, input last_of_frame, output ready);
endinterface

>>> hw/rtl/id3fw_parser.sv
// Parser state machine of the ID3v2 frame walker: consumes one accepted byte
// per cycle and produces at most one result record. Depends on id3fw_pkg.
module id3fw_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        accept_i,
  input  logic [id3fw_pkg::ByteW-1:0] tag_byte_i,
  input  logic                        start_of_tag_i,
  output logic                        push_o,
  output id3fw_pkg::result_t          res_o
);
  import id3fw_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TAGHDR, PH_EXTSIZE, PH_EXTSKIP,
    PH_FRAMEHDR, PH_PAYLOAD, PH_SKIP, PH_DONE
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [ShiftW-1:0]  shift_q, shift_d;
  logic [ByteW-1:0]   tflags_q, tflags_d;
  logic [SizeW-1:0]   trem_q, trem_d;
  logic [SizeW-1:0]   skip_q, skip_d;
  logic               emit_q;
  logic               push_d;
  result_t            res_d;

  phase_e             ph;
  logic [3:0]         cnt, cnt_inc;
  logic [ShiftW-1:0]  shift, shift_new;
  logic [ByteW-1:0]   tflags;
  logic [SizeW-1:0]   trem, skip, skip_syn, skip_dec, ext, size;
  logic [SizeW:0]     ext_sum, size_sum;

  always_comb begin
    if (start_of_tag_i) begin
      ph     = PH_TAGHDR;
      cnt    = '0;
      shift  = '0;
      tflags = '0;
      trem   = '0;
      skip   = '0;
    end else begin
      ph     = phase_q;
      cnt    = cnt_q;
      shift  = shift_q;
      tflags = tflags_q;
      trem   = trem_q;
      skip   = skip_q;
    end
    cnt_inc   = cnt + 4'd1;
    shift_new = {shift[ShiftW-9:0], tag_byte_i};
    skip_syn  = syn7(skip, tag_byte_i);
    skip_dec  = (skip != '0) ? skip - 28'd1 : skip;
    ext       = (skip_syn < ExtMin) ? ExtMin : skip_syn;
    ext_sum   = {1'b0, ext} + {1'b0, HdrLen};
    size      = skip;
    size_sum  = {1'b0, skip} + {1'b0, HdrLen};

    phase_d  = ph;
    cnt_d    = cnt;
    shift_d  = shift;
    tflags_d = tflags;
    trem_d   = trem;
    skip_d   = skip;
    push_d   = 1'b0;
    res_d    = '0;

    unique case (ph)
      PH_TAGHDR: begin
        if (cnt < 4'd6) begin
          shift_d = shift_new;
        end else begin
          trem_d = syn7(trem, tag_byte_i);
        end
        cnt_d = cnt_inc;
        if (cnt == 4'd2 && shift_new[23:0] != TagMagic) begin
          res_d.kind = KIND_NO_MAGIC;
          push_d     = 1'b1;
          phase_d    = PH_IDLE;
        end else if (cnt == 4'd5) begin
          tflags_d = tag_byte_i;
        end else if (cnt >= 4'd9) begin
          res_d.kind         = KIND_TAG_HDR;
          res_d.size_value   = trem_d;
          res_d.flag_bits    = {8'd0, tflags};
          res_d.tag_major    = shift[23:16];
          res_d.tag_revision = shift[15:8];
          push_d  = 1'b1;
          cnt_d   = '0;
          shift_d = '0;
          skip_d  = '0;
          if (tflags[6]) begin
            phase_d = PH_EXTSIZE;
          end else if (trem_d == '0) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_FRAMEHDR;
          end
        end
      end

      PH_EXTSIZE: begin
        skip_d = skip_syn;
        cnt_d  = cnt_inc;
        if (cnt_inc >= 4'd4) begin
          cnt_d = '0;
          if (ext_sum > {1'b0, trem}) begin
            res_d.kind       = KIND_EXT_LARGE;
            res_d.size_value = skip_syn;
            push_d = 1'b1;
            skip_d = (trem > ExtMin) ? trem - ExtMin : '0;
            phase_d = (skip_d != '0) ? PH_SKIP : PH_DONE;
          end else begin
            trem_d = trem - ext;
            skip_d = ext - ExtMin;
            if (skip_d != '0) begin
              phase_d = PH_EXTSKIP;
            end else begin
              shift_d = '0;
              phase_d = PH_FRAMEHDR;
            end
          end
        end
      end

      PH_EXTSKIP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          cnt_d   = '0;
          shift_d = '0;
          phase_d = PH_FRAMEHDR;
        end
      end

      PH_FRAMEHDR: begin
        if (cnt == 4'd0 && tag_byte_i == 8'd0) begin
          res_d.kind       = KIND_PADDING;
          res_d.size_value = trem;
          push_d  = 1'b1;
          skip_d  = (trem != '0) ? trem - 28'd1 : '0;
          phase_d = (skip_d != '0) ? PH_SKIP : PH_DONE;
        end else begin
          if (cnt < 4'd4 || cnt >= 4'd8) begin
            shift_d = shift_new;
          end else begin
            skip_d = skip_syn;
          end
          cnt_d = cnt_inc;
          if (cnt >= 4'd9) begin
            res_d.frame_id   = shift_new[47:16];
            res_d.size_value = size;
            res_d.flag_bits  = shift_new[15:0];
            push_d  = 1'b1;
            cnt_d   = '0;
            shift_d = '0;
            if ({1'b0, trem} < size_sum) begin
              res_d.kind = KIND_OVERFLOW;
              skip_d  = (trem > HdrLen) ? trem - HdrLen : '0;
              phase_d = (skip_d != '0) ? PH_SKIP : PH_DONE;
            end else begin
              res_d.kind = KIND_FRAME_HDR;
              trem_d = trem - size_sum[SizeW-1:0];
              if (size != '0) begin
                phase_d = PH_PAYLOAD;
              end else if (trem_d != '0) begin
                skip_d  = '0;
                phase_d = PH_FRAMEHDR;
              end else begin
                phase_d = PH_DONE;
              end
            end
          end
        end
      end

      PH_PAYLOAD: begin
        skip_d = skip_dec;
        if (emit_q) begin
          res_d.kind          = KIND_PAYLOAD;
          res_d.payload_byte  = tag_byte_i;
          res_d.last_of_frame = (skip_dec == '0);
          push_d = 1'b1;
        end
        if (skip_dec == '0) begin
          if (trem != '0) begin
            cnt_d   = '0;
            shift_d = '0;
            phase_d = PH_FRAMEHDR;
          end else begin
            phase_d = PH_DONE;
          end
        end
      end

      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = PH_DONE;
        end
      end

      PH_DONE: begin
        res_d.kind = KIND_TAG_END;
        push_d  = 1'b1;
        phase_d = PH_IDLE;
      end

      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      shift_q  <= '0;
      tflags_q <= '0;
      trem_q   <= '0;
      skip_q   <= '0;
      emit_q   <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        emit_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        shift_q  <= shift_d;
        tflags_q <= tflags_d;
        trem_q   <= trem_d;
        skip_q   <= skip_d;
      end
    end
  end

  assign push_o = accept_i & push_d;
  assign res_o  = res_d;

endmodule

>>> hw/rtl/id3fw_out_buf.sv
// Two-entry result queue of the ID3v2 frame walker, so that a new byte can be
// taken while a finished result waits. Depends on id3fw_pkg and id3fw_out_if.
module id3fw_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  id3fw_pkg::result_t res_i,
  output logic               space_o,
  id3fw_out_if.source        result_o
);
  import id3fw_pkg::*;

  logic [1:0] count_q, count_d;
  result_t    slot0_q, slot0_d, slot1_q, slot1_d;
  logic       pop;

  assign pop     = (count_q != 2'd0) & result_o.ready;
  assign space_o = (count_q != 2'd2);

  always_comb begin
    count_d = count_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    case (count_q)
      2'd0: begin
        if (push_i) begin
          slot0_d = res_i;
          count_d = 2'd1;
        end
      end
      2'd1: begin
        if (pop && push_i) begin
          slot0_d = res_i;
        end else if (pop) begin
          count_d = 2'd0;
        end else if (push_i) begin
          slot1_d = res_i;
          count_d = 2'd2;
        end
      end
      default: begin
        if (pop) begin
          slot0_d = slot1_q;
          count_d = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign result_o.valid         = (count_q != 2'd0);
  assign result_o.kind          = slot0_q.kind;
  assign result_o.frame_id      = slot0_q.frame_id;
  assign result_o.size_value    = slot0_q.size_value;
  assign result_o.flag_bits     = slot0_q.flag_bits;
  assign result_o.tag_major     = slot0_q.tag_major;
  assign result_o.tag_revision  = slot0_q.tag_revision;
  assign result_o.payload_byte  = slot0_q.payload_byte;
  assign result_o.last_of_frame = slot0_q.last_of_frame;

endmodule

>>> hw/rtl/id3fw_frame_walker_unit.sv
// Top level of the ID3v2 frame walker. Depends on id3fw_pkg, the two channel
// interfaces, id3fw_parser and id3fw_out_buf.
// A result is registered in the result queue before it is offered on result_o.
// Throughput: one byte per cycle; the two-entry result queue stops input only
// when both entries are full. Reset clears the parser to idle, empties the
// queue and sets emit_payload to 1.
module id3v2_frame_walker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  id3fw_in_if.sink    item_i,
  id3fw_out_if.source result_o
);
  import id3fw_pkg::*;

  logic    accept;
  logic    push;
  logic    space;
  result_t res;

  assign item_i.ready = space;
  assign accept       = item_i.valid & space;

  id3fw_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .tag_byte_i     (item_i.tag_byte),
    .start_of_tag_i (item_i.start_of_tag),
    .push_o         (push),
    .res_o          (res)
  );

  id3fw_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .res_i    (res),
    .space_o  (space),
    .result_o (result_o)
  );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for id3v2_frame_walker_unit. Streams of ID3v2 tag
// bytes are driven with random gaps and stalls, and every result transaction
// is checked against an in-bench model of the walker.
// Depends on id3fw_pkg, id3fw_in_if, id3fw_out_if and the walker RTL.
module tb_top;
  import id3fw_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_TAG_HDR,
    WALK_EXT_SIZE,
    WALK_EXT_SKIP,
    WALK_FRAME_HDR,
    WALK_PAYLOAD,
    WALK_SKIP,
    WALK_DONE
  } walk_e;

  typedef struct packed {
    logic [7:0] data;
    logic       sot;
  } tag_item_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  id3fw_in_if  item_if ();
  id3fw_out_if res_if ();

  id3v2_frame_walker_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_if),
    .result_o   (res_if)
  );

  walk_e       walk_phase;
  logic [3:0]  hdr_count;
  logic [63:0] hdr_shift;
  logic [7:0]  tag_flag_byte;
  logic [27:0] tag_left;
  logic [27:0] skip_count;
  logic        emit_payload_q;

  result_t     walker_reports[$];
  tag_item_t   tag_stream[$];
  tag_item_t   next_item;
  result_t     seen_rec;
  result_t     want_rec;
  logic        byte_taken;
  logic        byte_held;
  logic        in_calm;
  logic        out_calm;
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned report_errors;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic enter_frames();
    hdr_count  = '0;
    hdr_shift  = '0;
    skip_count = '0;
    walk_phase = WALK_FRAME_HDR;
  endtask

  task automatic skip_rest(input logic [27:0] n);
    skip_count = n;
    walk_phase = (n != 0) ? WALK_SKIP : WALK_DONE;
  endtask

  task automatic walk_tag_byte(input logic [7:0] b, input logic sot);
    result_t     rec;
    logic        hit;
    logic        last;
    logic [3:0]  cnt;
    logic [31:0] ext;
    rec = '0;
    hit = 1'b0;
    if (sot) begin
      walk_phase    = WALK_TAG_HDR;
      hdr_count     = '0;
      hdr_shift     = '0;
      tag_flag_byte = '0;
      tag_left      = '0;
      skip_count    = '0;
    end
    cnt = hdr_count;
    case (walk_phase)
      WALK_TAG_HDR: begin
        if (cnt < 6) hdr_shift = {hdr_shift[55:0], b};
        else tag_left = {tag_left[20:0], b[6:0]};
        hdr_count = cnt + 4'd1;
        if (cnt == 2 && hdr_shift[23:0] != TagMagic) begin
          rec.kind   = KIND_NO_MAGIC;
          hit        = 1'b1;
          walk_phase = WALK_IDLE;
        end else if (cnt == 5) begin
          tag_flag_byte = b;
        end else if (cnt >= 9) begin
          rec.kind         = KIND_TAG_HDR;
          rec.size_value   = tag_left;
          rec.flag_bits    = {8'h00, tag_flag_byte};
          rec.tag_major    = hdr_shift[23:16];
          rec.tag_revision = hdr_shift[15:8];
          hit              = 1'b1;
          hdr_count        = '0;
          hdr_shift        = '0;
          skip_count       = '0;
          if (tag_flag_byte[6]) walk_phase = WALK_EXT_SIZE;
          else if (tag_left == 0) walk_phase = WALK_DONE;
          else enter_frames();
        end
      end
      WALK_EXT_SIZE: begin
        skip_count = {skip_count[20:0], b[6:0]};
        hdr_count  = hdr_count + 4'd1;
        if (hdr_count >= 4) begin
          ext       = (skip_count < 4) ? 32'd4 : {4'h0, skip_count};
          hdr_count = '0;
          if (ext + 32'd10 > {4'h0, tag_left}) begin
            rec.kind       = KIND_EXT_LARGE;
            rec.size_value = skip_count;
            hit            = 1'b1;
            skip_rest(tag_left > 4 ? tag_left - 28'd4 : 28'd0);
          end else begin
            tag_left   = tag_left - ext[27:0];
            skip_count = ext[27:0] - 28'd4;
            if (skip_count != 0) walk_phase = WALK_EXT_SKIP;
            else enter_frames();
          end
        end
      end
      WALK_EXT_SKIP: begin
        if (skip_count != 0) skip_count = skip_count - 28'd1;
        if (skip_count == 0) enter_frames();
      end
      WALK_FRAME_HDR: begin
        if (cnt == 0 && b == 8'h00) begin
          rec.kind       = KIND_PADDING;
          rec.size_value = tag_left;
          hit            = 1'b1;
          skip_rest(tag_left != 0 ? tag_left - 28'd1 : 28'd0);
        end else begin
          if (cnt < 4 || cnt >= 8) hdr_shift = {hdr_shift[55:0], b};
          else skip_count = {skip_count[20:0], b[6:0]};
          hdr_count = cnt + 4'd1;
          if (cnt >= 9) begin
            rec.frame_id   = hdr_shift[47:16];
            rec.size_value = skip_count;
            rec.flag_bits  = hdr_shift[15:0];
            hit            = 1'b1;
            hdr_count      = '0;
            hdr_shift      = '0;
            if ({4'h0, tag_left} < {4'h0, skip_count} + 32'd10) begin
              rec.kind = KIND_OVERFLOW;
              skip_rest(tag_left > 10 ? tag_left - 28'd10 : 28'd0);
            end else begin
              rec.kind = KIND_FRAME_HDR;
              tag_left = tag_left - skip_count - 28'd10;
              if (skip_count != 0) walk_phase = WALK_PAYLOAD;
              else if (tag_left != 0) enter_frames();
              else walk_phase = WALK_DONE;
            end
          end
        end
      end
      WALK_PAYLOAD: begin
        if (skip_count != 0) skip_count = skip_count - 28'd1;
        last = (skip_count == 0);
        if (emit_payload_q) begin
          rec.kind          = KIND_PAYLOAD;
          rec.payload_byte  = b;
          rec.last_of_frame = last;
          hit               = 1'b1;
        end
        if (last) begin
          if (tag_left != 0) enter_frames();
          else walk_phase = WALK_DONE;
        end
      end
      WALK_SKIP: begin
        if (skip_count != 0) skip_count = skip_count - 28'd1;
        if (skip_count == 0) walk_phase = WALK_DONE;
      end
      WALK_DONE: begin
        rec.kind   = KIND_TAG_END;
        hit        = 1'b1;
        walk_phase = WALK_IDLE;
      end
      default: walk_phase = WALK_IDLE;
    endcase
    if (hit) walker_reports.push_back(rec);
  endtask

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    report_errors++;
    if (report_errors <= 10) begin
      $display("%s: expected kind %0d id %h size %h flags %h ver %h.%h byte %h last %b",
               what, want.kind, want.frame_id, want.size_value, want.flag_bits,
               want.tag_major, want.tag_revision, want.payload_byte,
               want.last_of_frame);
      $display("%s:      got kind %0d id %h size %h flags %h ver %h.%h byte %h last %b",
               what, got.kind, got.frame_id, got.size_value, got.flag_bits,
               got.tag_major, got.tag_revision, got.payload_byte,
               got.last_of_frame);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        seen_rec.kind          = kind_e'(res_if.kind);
        seen_rec.frame_id      = res_if.frame_id;
        seen_rec.size_value    = res_if.size_value;
        seen_rec.flag_bits     = res_if.flag_bits;
        seen_rec.tag_major     = res_if.tag_major;
        seen_rec.tag_revision  = res_if.tag_revision;
        seen_rec.payload_byte  = res_if.payload_byte;
        seen_rec.last_of_frame = res_if.last_of_frame;
        if (walker_reports.size() == 0) begin
          note_mismatch("unexpected result", '0, seen_rec);
        end else begin
          want_rec = walker_reports.pop_front();
          if (seen_rec !== want_rec) note_mismatch("result mismatch", want_rec, seen_rec);
        end
      end
      if (item_if.valid && item_if.ready) begin
        walk_tag_byte(item_if.tag_byte, item_if.start_of_tag);
        byte_taken = 1'b1;
      end
    end
  end

  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (byte_taken) begin
        byte_taken = 1'b0;
        byte_held  = 1'b0;
      end
      if (!byte_held) begin
        if (in_gap != 0) begin
          in_gap--;
          item_if.valid <= 1'b0;
        end else if (tag_stream.size() != 0) begin
          next_item = tag_stream.pop_front();
          item_if.valid        <= 1'b1;
          item_if.tag_byte     <= next_item.data;
          item_if.start_of_tag <= next_item.sot;
          byte_held = 1'b1;
          in_gap    = pick_gap(in_calm);
          if ($urandom_range(0, 63) == 0) in_calm = ~in_calm;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall != 0) begin
        out_stall--;
        res_if.ready <= 1'b0;
      end else if (!out_calm && $urandom_range(0, 3) == 0) begin
        out_stall = pick_gap(1'b0);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) out_calm = ~out_calm;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void put_synchsafe(ref byte_q_t q, input int unsigned v);
    for (int i = 3; i >= 0; i--) q.push_back({rand_byte() & 8'h80} | 8'((v >> (7 * i)) & 32'h7F));
  endfunction

  function automatic byte_q_t build_tag(input int nframes, input int max_pay,
                                        input int ext_size, input int pad_len,
                                        input int trim);
    byte_q_t    body;
    byte_q_t    tag;
    int         plen;
    int         declared;
    int         fill;
    logic [7:0] flags;
    body = {};
    tag  = {};
    if (ext_size >= 0) begin
      put_synchsafe(body, ext_size);
      fill = (ext_size > 16 || ext_size < 4) ? 0 : ext_size - 4;
      repeat (fill) body.push_back(rand_byte());
    end
    repeat (nframes) begin
      plen = $urandom_range(0, max_pay);
      body.push_back(8'($urandom_range(1, 255)));
      repeat (3) body.push_back(rand_byte());
      put_synchsafe(body, plen);
      repeat (2 + plen) body.push_back(rand_byte());
    end
    if (pad_len > 0) begin
      body.push_back(8'h00);
      repeat (pad_len - 1) body.push_back(rand_byte());
    end
    declared = (body.size() > trim) ? body.size() - trim : 0;
    flags    = rand_byte();
    flags[6] = (ext_size >= 0);
    tag.push_back(8'h49);
    tag.push_back(8'h44);
    tag.push_back(8'h33);
    tag.push_back(rand_byte());
    tag.push_back(rand_byte());
    tag.push_back(flags);
    put_synchsafe(tag, declared);
    foreach (body[i]) tag.push_back(body[i]);
    return tag;
  endfunction

  task automatic push_tag(input byte_q_t q, input int n);
    for (int i = 0; i < n && i < q.size(); i++) tag_stream.push_back('{data: q[i], sot: i == 0});
  endtask

  task automatic push_idle(input int n);
    repeat (n) tag_stream.push_back('{data: rand_byte(), sot: 1'b0});
  endtask

  task automatic queue_directed();
    byte_q_t    q;
    logic [7:0] big_tag [20];
    big_tag = '{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h54, 8'h49, 8'h54, 8'h32, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    push_idle(2);
    q = build_tag(0, 0, -1, 0, 0);
    push_tag(q, q.size());
    push_idle(1);
    q = build_tag(1, 2, -1, 0, 0);
    q[0] = 8'h58;
    push_tag(q, 3);
    q = build_tag(1, 2, -1, 0, 0);
    q[2] = 8'h34;
    push_tag(q, 3);
    q = {};
    foreach (big_tag[i]) q.push_back(big_tag[i]);
    push_tag(q, q.size());
    push_idle(2);
    q = build_tag(1, 1, 0, 3, 0);
    push_tag(q, q.size());
    push_idle(1);
    q = build_tag(0, 0, 28'h0FFFFFFF, 0, 0);
    push_tag(q, q.size());
    push_idle(1);
    q = build_tag(2, 0, -1, 0, 0);
    push_tag(q, q.size());
    push_idle(1);
    q = build_tag(1, 0, -1, 0, 5);
    push_tag(q, q.size());
    push_idle(4);
    q = build_tag(2, 4, -1, 0, 0);
    push_tag(q, 15);
    q = build_tag(3, 5, 6, 2, 0);
    push_tag(q, q.size());
    push_idle(1);
  endtask

  task automatic random_tags(input int budget);
    byte_q_t q;
    int      r;
    int      count;
    int      ext;
    int      cut;
    int      nb;
    count = 0;
    while (count < budget) begin
      r   = $urandom_range(0, 99);
      ext = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : -1;
      if (r < 80) begin
        q = build_tag($urandom_range(0, 4), $urandom_range(0, 7), ext,
                      ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0,
                      (r < 70) ? 0 : $urandom_range(1, 14));
        push_tag(q, q.size());
        count += q.size();
        if ($urandom_range(0, 3) != 0) begin
          push_idle(1);
          count++;
        end
      end else if (r < 86) begin
        q = build_tag(1, 3, -1, 0, 0);
        q[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
        push_tag(q, q.size());
        count += q.size();
      end else if (r < 92) begin
        q = build_tag($urandom_range(1, 3), 6, ext, 0, 0);
        cut = $urandom_range(1, q.size() - 1);
        push_tag(q, cut);
        count += cut;
      end else if (r < 96) begin
        ext = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 16)
                                          : $urandom_range(17, 28'h0FFFFFFF);
        q = build_tag(0, 0, ext, $urandom_range(0, 6), 0);
        push_tag(q, q.size());
        push_idle(1);
        count += q.size() + 1;
      end else begin
        nb = $urandom_range(1, 6);
        repeat (nb)
          tag_stream.push_back('{data: rand_byte(), sot: $urandom_range(0, 15) == 0});
        count += nb;
      end
    end
  endtask

  task automatic drain();
    while (tag_stream.size() != 0 || byte_held || walker_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_emit(input logic v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    emit_payload_q = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = 1'b0;
    item_if.valid        = 1'b0;
    item_if.tag_byte     = '0;
    item_if.start_of_tag = 1'b0;
    res_if.ready         = 1'b0;
    walk_phase           = WALK_IDLE;
    hdr_count            = '0;
    hdr_shift            = '0;
    tag_flag_byte        = '0;
    tag_left             = '0;
    skip_count           = '0;
    emit_payload_q       = 1'b1;
    byte_taken           = 1'b0;
    byte_held            = 1'b0;
    in_calm              = 1'b0;
    out_calm             = 1'b0;
    in_gap               = 0;
    out_stall            = 0;
    report_errors        = 0;
    cycle_count          = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    drain();
    set_emit(1'b0);
    random_tags(70);
    drain();
    set_emit(1'b1);
    random_tags(110);
    drain();
    set_emit(1'b0);
    random_tags(45);
    drain();
    set_emit(1'b1);
    random_tags(50);
    drain();
    repeat (8) @(posedge clk_i);
    if (report_errors == 0 && walker_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
